// File: sv/tlvp_pkg.sv
// ---------------------------------------------------------------------------
// TLV channel switch parser package
// Shared types and constants for the byte-serial TLV record parser.
// ---------------------------------------------------------------------------
package tlvp_pkg;

   // Record header codes that select a capture
   localparam logic [7:0] TAG_CHANNEL  = 8'h10;
   localparam logic [7:0] TYPE_CHANNEL = 8'h01;
   localparam logic [7:0] TAG_TIME     = 8'h11;
   localparam logic [7:0] TYPE_TIME    = 8'h03;

   localparam logic [15:0] LEN_CHANNEL = 16'd1;
   localparam logic [15:0] LEN_TIME    = 16'd4;

   // Header byte positions
   typedef enum logic [1:0] {
      HDR_TAG     = 2'd0,
      HDR_TYPE    = 2'd1,
      HDR_LEN_LO  = 2'd2,
      HDR_LEN_HI  = 2'd3
   } hdr_pos_type;

   // What the value bytes of the current record feed
   typedef enum logic [1:0] {
      TARGET_NONE    = 2'd0,
      TARGET_CHANNEL = 2'd1,
      TARGET_TIME    = 2'd2
   } target_type;

   // Frame status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_MISSING = 2'd1;
   localparam logic [1:0] STATUS_OVERRUN = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  switch_channel;
      logic [31:0] effective_time_ms;
   } result_type;

endpackage

// File: sv/tlvp_if.sv
// ---------------------------------------------------------------------------
// TLV parser stream interfaces
// Valid/ready channels for payload bytes in and frame results out.
// ---------------------------------------------------------------------------
interface tlvp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tlvp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  switch_channel;
   logic [31:0] effective_time_ms;

   modport source (output valid, output status, output switch_channel,
                   output effective_time_ms, input ready);
   modport sink   (input valid, input status, input switch_channel,
                   input effective_time_ms, output ready);
endinterface

// File: sv/tlvp_in_reg.sv
// ---------------------------------------------------------------------------
// TLV parser input register
// Holds one payload byte until the parse stage takes it.
// ---------------------------------------------------------------------------
module tlvp_in_reg (
   input  logic              clock,
   input  logic              reset,
   tlvp_req_if.sink          req_chan,
   input  logic              advance,
   output logic              item_valid,
   output tlvp_pkg::item_type item
);
   import tlvp_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // Take a new transfer when empty or when the held byte moves on
   assign req_chan.ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b0;
      end
      if (req_chan.valid && req_chan.ready) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload on each transfer
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff.data_byte <= req_chan.data_byte;
         item_ff.last_byte <= req_chan.last_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: sv/tlvp_engine.sv
// ---------------------------------------------------------------------------
// TLV parser engine
// Per-byte record state update, captures and end-of-frame result.
// ---------------------------------------------------------------------------
module tlvp_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  tlvp_pkg::item_type  item,
   output logic                res_valid,
   output tlvp_pkg::result_type result
);
   import tlvp_pkg::*;

   hdr_pos_type hdr_pos_ff,   hdr_pos_in;
   logic        in_value_ff,  in_value_in;
   logic [7:0]  tag_ff,       tag_in;
   logic [7:0]  type_ff,      type_in;
   logic [7:0]  len_lo_ff,    len_lo_in;
   logic [15:0] remain_ff,    remain_in;
   target_type  target_ff,    target_in;
   logic [31:0] shift_ff,     shift_in;
   logic [7:0]  channel_ff,   channel_in;
   logic [31:0] time_ff,      time_in;
   logic        have_ch_ff,   have_ch_in;
   logic        got_time_ff,  got_time_in;

   logic [15:0] hdr_len;
   logic        overrun;

   // Captures as they stand after this byte, before the frame clear
   logic        cap_have_ch;
   logic        cap_got_time;
   logic [7:0]  cap_ch_val;
   logic [31:0] cap_time_val;

   assign hdr_len = {item.data_byte, len_lo_ff};

   // Advance the record state by one byte, then close the frame on its last byte
   always_comb begin
      hdr_pos_in   = hdr_pos_ff;
      in_value_in  = in_value_ff;
      tag_in       = tag_ff;
      type_in      = type_ff;
      len_lo_in    = len_lo_ff;
      remain_in    = remain_ff;
      target_in    = target_ff;
      shift_in     = shift_ff;
      channel_in   = channel_ff;
      time_in      = time_ff;
      have_ch_in   = have_ch_ff;
      got_time_in  = got_time_ff;
      overrun      = 1'b0;

      if (step) begin
         if (in_value_ff) begin
            // Value byte: shift in newest at the top, count down
            shift_in  = {item.data_byte, shift_ff[31:8]};
            remain_in = remain_ff - 16'd1;
            if (remain_in == 16'd0) begin
               if (target_ff == TARGET_CHANNEL) begin
                  channel_in = item.data_byte;
                  have_ch_in = 1'b1;
               end else if (target_ff == TARGET_TIME) begin
                  time_in     = shift_in;
                  got_time_in = 1'b1;
               end
               in_value_in = 1'b0;
               target_in   = TARGET_NONE;
            end
         end else begin
            unique case (hdr_pos_ff)
               HDR_TAG: begin
                  tag_in     = item.data_byte;
                  hdr_pos_in = HDR_TYPE;
               end
               HDR_TYPE: begin
                  type_in    = item.data_byte;
                  hdr_pos_in = HDR_LEN_LO;
               end
               HDR_LEN_LO: begin
                  len_lo_in  = item.data_byte;
                  hdr_pos_in = HDR_LEN_HI;
               end
               HDR_LEN_HI: begin
                  hdr_pos_in = HDR_TAG;
                  // Zero length records complete here and capture nothing
                  if (hdr_len != 16'd0) begin
                     in_value_in = 1'b1;
                     remain_in   = hdr_len;
                     shift_in    = '0;
                     if (tag_ff == TAG_CHANNEL && type_ff == TYPE_CHANNEL &&
                         hdr_len == LEN_CHANNEL) begin
                        target_in = TARGET_CHANNEL;
                     end else if (tag_ff == TAG_TIME && type_ff == TYPE_TIME &&
                                  hdr_len == LEN_TIME) begin
                        target_in = TARGET_TIME;
                     end else begin
                        target_in = TARGET_NONE;
                     end
                  end
               end
               default: begin
                  hdr_pos_in = HDR_TAG;
               end
            endcase
         end

         // Frame ends still inside a value: overrun
         overrun = in_value_in;

         if (item.last_byte) begin
            hdr_pos_in   = HDR_TAG;
            in_value_in  = 1'b0;
            tag_in       = '0;
            type_in      = '0;
            len_lo_in    = '0;
            remain_in    = '0;
            target_in    = TARGET_NONE;
            shift_in     = '0;
            channel_in   = '0;
            time_in      = '0;
            have_ch_in   = 1'b0;
            got_time_in  = 1'b0;
         end
      end
   end

   // Fold in a capture that completes on this byte
   always_comb begin
      cap_have_ch  = have_ch_ff;
      cap_got_time = got_time_ff;
      cap_ch_val   = channel_ff;
      cap_time_val = time_ff;
      if (in_value_ff && remain_ff == 16'd1) begin
         if (target_ff == TARGET_CHANNEL) begin
            cap_have_ch = 1'b1;
            cap_ch_val  = item.data_byte;
         end else if (target_ff == TARGET_TIME) begin
            cap_got_time = 1'b1;
            cap_time_val = {item.data_byte, shift_ff[31:8]};
         end
      end
   end

   // Build the frame result from the updated captures
   always_comb begin
      res_valid = step && item.last_byte;
      if (overrun) begin
         result.status = STATUS_OVERRUN;
      end else if (cap_have_ch && cap_got_time) begin
         result.status = STATUS_OK;
      end else begin
         result.status = STATUS_MISSING;
      end
      result.switch_channel    = cap_have_ch  ? cap_ch_val   : 8'd0;
      result.effective_time_ms = cap_got_time ? cap_time_val : 32'd0;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_pos_ff   <= HDR_TAG;
         in_value_ff  <= 1'b0;
         remain_ff    <= '0;
         target_ff    <= TARGET_NONE;
         have_ch_ff   <= 1'b0;
         got_time_ff  <= 1'b0;
      end else begin
         hdr_pos_ff   <= hdr_pos_in;
         in_value_ff  <= in_value_in;
         remain_ff    <= remain_in;
         target_ff    <= target_in;
         have_ch_ff   <= have_ch_in;
         got_time_ff  <= got_time_in;
      end
   end

   // Held header bytes, value shifter and captures
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff     <= '0;
         type_ff    <= '0;
         len_lo_ff  <= '0;
         shift_ff   <= '0;
         channel_ff <= '0;
         time_ff    <= '0;
      end else begin
         tag_ff     <= tag_in;
         type_ff    <= type_in;
         len_lo_ff  <= len_lo_in;
         shift_ff   <= shift_in;
         channel_ff <= channel_in;
         time_ff    <= time_in;
      end
   end

   // A value in progress always has bytes still due
   a_remain_nonzero: assert property (@(posedge clock) disable iff (reset)
      in_value_ff |-> (remain_ff != 16'd0))
      else $error("value in progress with zero bytes remaining");

   // A capture target exists only inside a value
   a_target_in_value: assert property (@(posedge clock) disable iff (reset)
      (target_ff != TARGET_NONE) |-> in_value_ff)
      else $error("capture target set outside a value");

   // The frame state is clear after a result
   a_frame_cleared: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> (hdr_pos_ff == HDR_TAG && !in_value_ff && !have_ch_ff &&
                     !got_time_ff))
      else $error("frame state not cleared after result");

endmodule

// File: sv/tlvp_out_reg.sv
// ---------------------------------------------------------------------------
// TLV parser result register
// Holds one frame result until the sink takes it.
// ---------------------------------------------------------------------------
module tlvp_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  tlvp_pkg::result_type result,
   output logic                 full,
   tlvp_rsp_if.source           rsp_chan
);
   import tlvp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_chan.valid && rsp_chan.ready) begin
         valid_in = 1'b0;
      end
      if (res_valid) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load a new result
   always_ff @(posedge clock) begin
      if (res_valid) begin
         result_ff <= result;
      end
   end

   assign full                       = valid_ff;
   assign rsp_chan.valid             = valid_ff;
   assign rsp_chan.status            = result_ff.status;
   assign rsp_chan.switch_channel    = result_ff.switch_channel;
   assign rsp_chan.effective_time_ms = result_ff.effective_time_ms;

endmodule

// File: sv/tlv_channel_switch_parser.sv
// ---------------------------------------------------------------------------
// TLV channel switch parser
// Byte-serial TLV payload parser that captures a channel and a switch time.
// ---------------------------------------------------------------------------
// The parser takes one payload byte per cycle with no gaps of its own and
// returns one result per frame. A byte lands in the input register at its
// transfer; from there the per-byte state update consumes it and, for a
// frame's last byte, loads the result register, which offers the result to
// the sink. While a result waits to be taken, bytes that do not end a frame
// keep flowing; a last byte waits in the input register until the result
// register frees up, which it does in the same cycle the sink takes it.
module tlv_channel_switch_parser (
   input  logic        clock,
   input  logic        reset,
   tlvp_req_if.sink    req_chan,
   tlvp_rsp_if.source  rsp_chan
);
   import tlvp_pkg::*;

   logic       item_valid;
   item_type   item;
   logic       advance;
   logic       res_valid;
   result_type result;
   logic       out_full;

   // Move a byte on unless it closes a frame and the result slot is busy
   assign advance = item_valid && (!item.last_byte || !out_full || rsp_chan.ready);

   tlvp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   tlvp_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (item),
      .res_valid (res_valid),
      .result    (result)
   );

   tlvp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .result    (result),
      .full      (out_full),
      .rsp_chan  (rsp_chan)
   );

   // A new result never lands on one that is still waiting
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (!out_full || rsp_chan.ready))
      else $error("result overwrites a pending result");

endmodule
